// ===== src/indexed_list_engine_macros.svh =====
// Assertion macros for the indexed list engine.
`ifndef INDEXED_LIST_ENGINE_MACROS_SVH
`define INDEXED_LIST_ENGINE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define ILE_CHECK(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define ILE_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/ile_pkg.sv =====
// Shared types and constants of the indexed list engine.
package ile_pkg;

  localparam int OP_W       = 4;
  localparam int POS_W      = 7;
  localparam int POS2_W     = 6;
  localparam int RD_W       = 32;
  localparam int STEP_W     = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;
  localparam int OUT_DATA_W = ((RD_W + 2 * POS_W + 7) / 8) * 8;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT   = 4'd0,
    OP_APPEND   = 4'd1,
    OP_REMOVE   = 4'd2,
    OP_POP      = 4'd3,
    OP_DEQUEUE  = 4'd4,
    OP_READ     = 4'd5,
    OP_WRITE    = 4'd6,
    OP_FIND     = 4'd7,
    OP_REMVAL   = 4'd8,
    OP_EXCHANGE = 4'd9,
    OP_CLEAR    = 4'd10
  } ile_op_e_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GROW   = 2'd0,
    CFG_SHRINK = 2'd1,
    CFG_STEP   = 2'd2,
    CFG_INIT   = 2'd3
  } ile_cfg_e_t;

  // Command broadcast along the row of cells.
  typedef enum logic [2:0] {
    CELL_HOLD = 3'd0,
    CELL_INS  = 3'd1,
    CELL_DEL  = 3'd2,
    CELL_WR   = 3'd3,
    CELL_SWAP = 3'd4
  } ile_cell_op_t;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_APPLY = 3'b100
  } ile_state_t;

endpackage

// ===== src/ile_cell.sv =====
// One list entry: holds a word, shifts with its neighbors, compares and reads out.
module ile_cell import ile_pkg::*; #(
  parameter int CELL_IDX    = 0,
  parameter int VALUE_WIDTH = 32,
  parameter int IDX_W       = 6,
  parameter int CNT_W       = 7
) (
  input  logic                   clk,
  input  ile_cell_op_t           cell_op,
  input  logic [IDX_W-1:0]       idx_a,
  input  logic [IDX_W-1:0]       idx_b,
  input  logic [CNT_W-1:0]       lim,
  input  logic [VALUE_WIDTH-1:0] data_a,
  input  logic [VALUE_WIDTH-1:0] data_b,
  input  logic [VALUE_WIDTH-1:0] key,
  input  logic [VALUE_WIDTH-1:0] left_in,
  input  logic [VALUE_WIDTH-1:0] right_in,
  output logic [VALUE_WIDTH-1:0] ent,
  output logic                   hit,
  output logic [VALUE_WIDTH-1:0] rd_a,
  output logic [VALUE_WIDTH-1:0] rd_b
);

  localparam logic [IDX_W-1:0] MY_IDX  = IDX_W'(CELL_IDX);
  localparam logic [CNT_W-1:0] MY_CNT  = CNT_W'(CELL_IDX);
  localparam logic [CNT_W-1:0] NXT_CNT = CNT_W'(CELL_IDX + 1);

  logic [VALUE_WIDTH-1:0] ent_r;
  logic [VALUE_WIDTH-1:0] ent_nxt;
  logic                   is_a;
  logic                   is_b;

  assign is_a = (idx_a == MY_IDX);
  assign is_b = (idx_b == MY_IDX);

  always_comb begin
    ent_nxt = ent_r;
    unique case (cell_op)
      CELL_INS: begin
        // entries from the slot up to the old tail move one place up
        if (is_a) begin
          ent_nxt = data_a;
        end else if (MY_IDX > idx_a && MY_CNT <= lim) begin
          ent_nxt = left_in;
        end
      end
      CELL_DEL: begin
        if (MY_IDX >= idx_a && NXT_CNT < lim) begin
          ent_nxt = right_in;
        end
      end
      CELL_WR: begin
        if (is_a) begin
          ent_nxt = data_a;
        end
      end
      CELL_SWAP: begin
        if (is_a) begin
          ent_nxt = data_b;
        end else if (is_b) begin
          ent_nxt = data_a;
        end
      end
      default: ent_nxt = ent_r;
    endcase
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  assign ent  = ent_r;
  assign hit  = (ent_r == key) && (MY_CNT < lim);
  assign rd_a = is_a ? ent_r : '0;
  assign rd_b = is_b ? ent_r : '0;

endmodule

// ===== src/ile_chain.sv =====
// Row of list cells with read-out and first-match reduction.
module ile_chain import ile_pkg::*; #(
  parameter int CAPACITY    = 64,
  parameter int VALUE_WIDTH = 32,
  parameter int IDX_W       = 6,
  parameter int CNT_W       = 7
) (
  input  logic                   clk,
  input  ile_cell_op_t           cell_op,
  input  logic [IDX_W-1:0]       idx_a,
  input  logic [IDX_W-1:0]       idx_b,
  input  logic [CNT_W-1:0]       lim,
  input  logic [VALUE_WIDTH-1:0] data_a,
  input  logic [VALUE_WIDTH-1:0] data_b,
  input  logic [VALUE_WIDTH-1:0] key,
  output logic [VALUE_WIDTH-1:0] rd_a,
  output logic [VALUE_WIDTH-1:0] rd_b,
  output logic                   hit_ok,
  output logic [IDX_W-1:0]       hit_idx
);

  logic [VALUE_WIDTH-1:0] ent  [CAPACITY];
  logic [VALUE_WIDTH-1:0] ra   [CAPACITY];
  logic [VALUE_WIDTH-1:0] rb   [CAPACITY];
  logic [CAPACITY-1:0]    hits;
  logic [CAPACITY-1:0]    first;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VALUE_WIDTH-1:0] left_v;
    logic [VALUE_WIDTH-1:0] right_v;

    if (i == 0) begin : g_head
      assign left_v = '0;
    end else begin : g_left
      assign left_v = ent[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign right_v = '0;
    end else begin : g_right
      assign right_v = ent[i+1];
    end

    ile_cell #(
      .CELL_IDX    (i),
      .VALUE_WIDTH (VALUE_WIDTH),
      .IDX_W       (IDX_W),
      .CNT_W       (CNT_W)
    ) u_cell (
      .clk      (clk),
      .cell_op  (cell_op),
      .idx_a    (idx_a),
      .idx_b    (idx_b),
      .lim      (lim),
      .data_a   (data_a),
      .data_b   (data_b),
      .key      (key),
      .left_in  (left_v),
      .right_in (right_v),
      .ent      (ent[i]),
      .hit      (hits[i]),
      .rd_a     (ra[i]),
      .rd_b     (rb[i])
    );
  end

  // lowest set match bit, isolated
  assign first  = hits & (~hits + CAPACITY'(1));
  assign hit_ok = |hits;

  always_comb begin
    rd_a    = '0;
    rd_b    = '0;
    hit_idx = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_a = rd_a | ra[i];
      rd_b = rd_b | rb[i];
      if (first[i]) begin
        hit_idx = hit_idx | IDX_W'(i);
      end
    end
  end

endmodule

// ===== src/indexed_list_engine.sv =====
// Top level of the indexed list engine: control, sizing and result register.
//
// Ordered list of up to CAPACITY words, kept in a row of cells that shift
// together on insert and remove. One operation enters per transaction on the
// in_ channel (operation in in_tuser, indexes and value in in_tdata) and
// yields exactly one result transaction on the out_ channel.
// Timing: an accepted operation is looked up in the scan state (read-out and
// match search across all cells, registered) and applied in the apply state,
// where the result is loaded into the output register. in_tready is high only
// while the controller is idle, so a new operation is not taken before the
// last one has been applied; the lookup and apply steps share the cell row.
// If the receiver stalls, the result waits in the output register; one
// further operation can still be accepted and looked up, and its apply step
// then waits with the cells unchanged until the output register frees.
// Configuration writes (cfg_) are always accepted and take effect at once;
// they are meant to be issued only while no operation is in flight.
// Reset (rst_n low, synchronous) empties the list, restores the register
// defaults and sets the logical size to zero. Entry contents are not reset;
// only live entries are ever read.
`include "indexed_list_engine_macros.svh"

module indexed_list_engine import ile_pkg::*; #(
  parameter int CAPACITY    = 64,
  parameter int VALUE_WIDTH = 32,
  localparam int IN_DATA_W  = ((POS_W + POS2_W + VALUE_WIDTH + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // in_tdata: position, other_position, item_value (low to high), zero pad
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // in_tuser: operation
  input  logic [OP_W-1:0]       in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // out_tdata: read_value, found_position, entry_count (low to high), zero pad
  output logic [OUT_DATA_W-1:0] out_tdata,
  // out_tuser: success
  output logic                  out_tuser,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int SUM_W = CNT_W + STEP_W + 1;

  ile_state_t             state_r, state_nxt;
  logic [OP_W-1:0]        op_r;
  logic [POS_W-1:0]       pos_r;
  logic [POS2_W-1:0]      pos2_r;
  logic [VALUE_WIDTH-1:0] val_r;
  logic [CNT_W-1:0]       count_r, count_nxt;
  logic [CNT_W-1:0]       size_r, size_nxt;
  logic                   grow_r, shrink_r;
  logic [STEP_W-1:0]      step_r, init_r;

  // lookup results
  logic                   hit_ok_r;
  logic [IDX_W-1:0]       hit_idx_r;
  logic [VALUE_WIDTH-1:0] rd_a_r, rd_b_r;

  // result register
  logic                   out_valid_r;
  logic                   out_ok_r;
  logic [RD_W-1:0]        out_rd_r;
  logic [POS_W-1:0]       out_fp_r;
  logic [POS_W-1:0]       out_cnt_r;

  logic                   in_fire;
  logic                   fire;
  logic [IDX_W-1:0]       tgt;
  logic [IDX_W-1:0]       idx_a;
  logic [IDX_W-1:0]       idx_b;
  logic [VALUE_WIDTH-1:0] data_a;
  ile_cell_op_t           cell_op, apply_op;
  logic                   hit_ok;
  logic [IDX_W-1:0]       hit_idx;
  logic [VALUE_WIDTH-1:0] rd_a, rd_b;

  logic [CMP_W-1:0]       pos_ext, pos2_ext, cnt_ext, ins_pos;
  logic [CNT_W-1:0]       cnt_dec;
  logic [CNT_W-1:0]       load_size;
  logic                   grow_fail;
  logic                   shrink_ok;
  logic                   ok;
  logic [VALUE_WIDTH-1:0] rd_val;
  logic [POS_W-1:0]       fp_val;

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign fire      = (state_r == ST_APPLY) && (!out_valid_r || out_tready);
  assign cfg_ready = 1'b1;

  // Controller
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_fire) state_nxt = ST_SCAN;
      ST_SCAN:  state_nxt = ST_APPLY;
      ST_APPLY: if (fire) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Latched operation
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r   <= in_tuser;
      pos_r  <= in_tdata[POS_W-1:0];
      pos2_r <= in_tdata[POS_W +: POS2_W];
      val_r  <= in_tdata[POS_W + POS2_W +: VALUE_WIDTH];
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grow_r   <= 1'b1;
      shrink_r <= 1'b0;
      step_r   <= STEP_W'(1);
      init_r   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_GROW:   grow_r   <= cfg_data[0];
        CFG_SHRINK: shrink_r <= cfg_data[0];
        CFG_STEP:   step_r   <= STEP_W'(cfg_data);
        CFG_INIT:   init_r   <= STEP_W'(cfg_data);
        default:    grow_r   <= grow_r;
      endcase
    end
  end

  // Cell addressing: the slot an operation works on
  always_comb begin
    case (op_r)
      OP_APPEND:  tgt = IDX_W'(count_r);
      OP_POP:     tgt = IDX_W'(count_r - CNT_W'(1));
      OP_DEQUEUE: tgt = '0;
      default:    tgt = IDX_W'(pos_r);
    endcase
  end

  // remove-by-value acts on the matched slot found during lookup
  assign idx_a   = (state_r == ST_APPLY && op_r == OP_REMVAL) ? hit_idx_r : tgt;
  assign idx_b   = IDX_W'(pos2_r);
  assign data_a  = (apply_op == CELL_SWAP) ? rd_a_r : val_r;
  assign cell_op = fire ? apply_op : CELL_HOLD;

  ile_chain #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (VALUE_WIDTH),
    .IDX_W       (IDX_W),
    .CNT_W       (CNT_W)
  ) u_chain (
    .clk     (clk),
    .cell_op (cell_op),
    .idx_a   (idx_a),
    .idx_b   (idx_b),
    .lim     (count_r),
    .data_a  (data_a),
    .data_b  (rd_b_r),
    .key     (val_r),
    .rd_a    (rd_a),
    .rd_b    (rd_b),
    .hit_ok  (hit_ok),
    .hit_idx (hit_idx)
  );

  always_ff @(posedge clk) begin
    if (state_r == ST_SCAN) begin
      rd_a_r    <= rd_a;
      rd_b_r    <= rd_b;
      hit_ok_r  <= hit_ok;
      hit_idx_r <= hit_idx;
    end
  end

  // Apply step: success, new count and logical size, cell command
  assign pos_ext  = CMP_W'(pos_r);
  assign pos2_ext = CMP_W'(pos2_r);
  assign cnt_ext  = CMP_W'(count_r);
  assign ins_pos  = (op_r == OP_APPEND) ? cnt_ext : pos_ext;
  assign cnt_dec  = count_r - CNT_W'(1);

  assign load_size = (SUM_W'(init_r) > SUM_W'(CAPACITY)) ? CNT_W'(CAPACITY)
                                                         : CNT_W'(init_r);
  assign grow_fail = !grow_r || (step_r == '0) ||
                     (SUM_W'(size_r) + SUM_W'(step_r) > SUM_W'(CAPACITY));
  // shrink only when the count drops below size minus one step
  assign shrink_ok = shrink_r && (SUM_W'(step_r) <= SUM_W'(size_r)) &&
                     (SUM_W'(cnt_dec) < SUM_W'(size_r) - SUM_W'(step_r));

  always_comb begin
    ok        = 1'b0;
    count_nxt = count_r;
    size_nxt  = size_r;
    apply_op  = CELL_HOLD;
    rd_val    = '0;
    fp_val    = '0;
    case (op_r) inside
      OP_INSERT, OP_APPEND: begin
        if (ins_pos <= cnt_ext && SUM_W'(count_r) < SUM_W'(CAPACITY) &&
            !(count_r >= size_r && grow_fail)) begin
          ok        = 1'b1;
          apply_op  = CELL_INS;
          count_nxt = count_r + CNT_W'(1);
          if (count_r >= size_r) begin
            size_nxt = CNT_W'(SUM_W'(size_r) + SUM_W'(step_r));
          end
          fp_val = (op_r == OP_APPEND) ? POS_W'(count_r) : pos_r;
        end
      end
      OP_REMOVE, OP_POP, OP_DEQUEUE, OP_REMVAL: begin
        if ((op_r == OP_REMOVE && pos_ext < cnt_ext) ||
            ((op_r == OP_POP || op_r == OP_DEQUEUE) && count_r != '0) ||
            (op_r == OP_REMVAL && hit_ok_r)) begin
          ok        = 1'b1;
          apply_op  = CELL_DEL;
          count_nxt = cnt_dec;
          if (shrink_ok) begin
            size_nxt = CNT_W'(SUM_W'(size_r) - SUM_W'(step_r));
          end
          rd_val = (op_r == OP_REMVAL) ? val_r : rd_a_r;
          if (op_r == OP_REMVAL) begin
            fp_val = POS_W'(hit_idx_r);
          end
        end
      end
      OP_READ: begin
        if (pos_ext < cnt_ext) begin
          ok     = 1'b1;
          rd_val = rd_a_r;
        end
      end
      OP_WRITE: begin
        if (pos_ext < cnt_ext) begin
          ok       = 1'b1;
          apply_op = CELL_WR;
        end
      end
      OP_FIND: begin
        ok = hit_ok_r;
        if (hit_ok_r) begin
          fp_val = POS_W'(hit_idx_r);
        end
      end
      OP_EXCHANGE: begin
        if (pos_ext < cnt_ext && pos2_ext < cnt_ext) begin
          ok       = 1'b1;
          apply_op = CELL_SWAP;
        end
      end
      OP_CLEAR: begin
        ok        = 1'b1;
        count_nxt = '0;
        size_nxt  = load_size;
      end
      default: ok = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      size_r  <= '0;
    end else if (fire) begin
      count_r <= count_nxt;
      size_r  <= size_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_ok_r  <= ok;
      out_rd_r  <= RD_W'(rd_val);
      out_fp_r  <= fp_val;
      out_cnt_r <= POS_W'(count_nxt);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_ok_r;
  assign out_tdata  = OUT_DATA_W'({out_cnt_r, out_fp_r, out_rd_r});

  // Checks
  `ILE_CHECK(a_count_le_size, 1'b1, count_r <= size_r, "count above logical size")
  `ILE_CHECK(a_size_le_cap, 1'b1, SUM_W'(size_r) <= SUM_W'(CAPACITY), "size above capacity")
  `ILE_CHECK_NEXT(a_scan_after_accept, in_fire, state_r == ST_SCAN, "no lookup after accept")
  `ILE_CHECK(a_result_from_apply, $rose(out_valid_r), $past(state_r) == ST_APPLY, "stray result")

endmodule

// ===== tb/sv/indexed_list_engine_test.sv =====
// Self-checking testbench for the indexed list engine: directed and random operations.
`timescale 1ns / 1ps

module indexed_list_engine_test;
  import ile_pkg::*;

  localparam int CAP   = 64;
  localparam int VAL_W = 32;
  localparam int IN_W  = ((POS_W + POS2_W + VAL_W + 7) / 8) * 8;
  localparam int PAD_W = IN_W - POS_W - POS2_W - VAL_W;

  // Top of the unused operation codes; everything above OP_CLEAR must fail.
  localparam logic [OP_W-1:0] OP_UNKNOWN_HI = 4'hF;

  typedef struct packed {
    logic             success;
    logic [RD_W-1:0]  read_value;
    logic [POS_W-1:0] found_position;
    logic [POS_W-1:0] entry_count;
  } list_reply_t;

  typedef enum int {MIX_FILL, MIX_BALANCED, MIX_DRAIN} op_mix_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_W-1:0]       in_tdata   = '0;
  logic [OP_W-1:0]       in_tuser   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  indexed_list_engine #(
    .CAPACITY    (CAP),
    .VALUE_WIDTH (VAL_W)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow of the list and its sizing registers, advanced at each accepted transaction.
  logic [VAL_W-1:0] list_mem [CAP];
  int               live_count = 0;
  int               alloc_size = 0;
  bit               grow_en    = 1'b1;
  bit               shrink_en  = 1'b0;
  int               step_amt   = 1;
  int               init_size  = 0;

  list_reply_t pending_replies[$];

  bit idle_en         = 1'b1;
  int stall_left      = 0;
  int fail_count      = 0;
  int ops_sent        = 0;
  int replies_checked = 0;
  int settings_used   = 0;
  int peak_count      = 0;

  ile_op_e_t op_order[11] = '{OP_INSERT, OP_APPEND, OP_REMOVE, OP_POP, OP_DEQUEUE, OP_READ,
                              OP_WRITE, OP_FIND, OP_REMVAL, OP_EXCHANGE, OP_CLEAR};

  logic [VAL_W-1:0] value_pool[8] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000,
                                      32'h0000_0001, 32'h5555_5555, 32'hAAAA_AAAA,
                                      32'h1234_5678, 32'hDEAD_BEEF};

  // ---------------------------------------------------------------- prediction

  function automatic bit list_insert(int at, logic [VAL_W-1:0] v);
    if (at > live_count || live_count >= CAP) return 1'b0;
    if (live_count >= alloc_size) begin
      if (!grow_en || step_amt == 0 || alloc_size + step_amt > CAP) return 1'b0;
      alloc_size += step_amt;
    end
    for (int i = live_count; i > at; i--) list_mem[i] = list_mem[i-1];
    list_mem[at] = v;
    live_count++;
    return 1'b1;
  endfunction

  // Shrink only when the count drops below the size minus one step.
  function automatic logic [VAL_W-1:0] list_remove(int at);
    logic [VAL_W-1:0] v;
    v = list_mem[at];
    live_count--;
    for (int i = at; i < live_count; i++) list_mem[i] = list_mem[i+1];
    if (shrink_en && step_amt <= alloc_size && live_count < alloc_size - step_amt)
      alloc_size -= step_amt;
    return v;
  endfunction

  function automatic bit list_find(logic [VAL_W-1:0] v, output int where);
    where = 0;
    for (int i = 0; i < live_count; i++) begin
      if (list_mem[i] == v) begin
        where = i;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic list_reply_t compute_list_reply(logic [OP_W-1:0] op,
      logic [POS_W-1:0] pos, logic [POS2_W-1:0] pos2, logic [VAL_W-1:0] val);
    list_reply_t r;
    int at;
    logic [VAL_W-1:0] t;
    r = '0;
    case (op)
      OP_INSERT: begin
        r.success = list_insert(int'(pos), val);
        if (r.success) r.found_position = pos;
      end
      OP_APPEND: begin
        r.success = list_insert(live_count, val);
        if (r.success) r.found_position = POS_W'(live_count - 1);
      end
      OP_REMOVE: if (int'(pos) < live_count) begin
        r.read_value = list_remove(int'(pos));
        r.success = 1'b1;
      end
      OP_POP: if (live_count > 0) begin
        r.read_value = list_remove(live_count - 1);
        r.success = 1'b1;
      end
      OP_DEQUEUE: if (live_count > 0) begin
        r.read_value = list_remove(0);
        r.success = 1'b1;
      end
      OP_READ: if (int'(pos) < live_count) begin
        r.read_value = list_mem[pos];
        r.success = 1'b1;
      end
      OP_WRITE: if (int'(pos) < live_count) begin
        list_mem[pos] = val;
        r.success = 1'b1;
      end
      OP_FIND: begin
        r.success = list_find(val, at);
        if (r.success) r.found_position = POS_W'(at);
      end
      OP_REMVAL: begin
        r.success = list_find(val, at);
        if (r.success) begin
          r.found_position = POS_W'(at);
          r.read_value = list_remove(at);
        end
      end
      OP_EXCHANGE: if (int'(pos) < live_count && int'(pos2) < live_count) begin
        t = list_mem[pos];
        list_mem[pos] = list_mem[pos2];
        list_mem[pos2] = t;
        r.success = 1'b1;
      end
      OP_CLEAR: begin
        // size reloads from the register, saturated at capacity
        live_count = 0;
        alloc_size = (init_size > CAP) ? CAP : init_size;
        r.success = 1'b1;
      end
      default: ;
    endcase
    r.entry_count = POS_W'(live_count);
    return r;
  endfunction

  // ---------------------------------------------------------------- result side

  task automatic check_reply();
    list_reply_t want;
    list_reply_t got;
    got.success        = out_tuser;
    got.read_value     = out_tdata[RD_W-1:0];
    got.found_position = out_tdata[RD_W +: POS_W];
    got.entry_count    = out_tdata[RD_W + POS_W +: POS_W];
    if (pending_replies.size() == 0) begin
      $error("unexpected result transaction: success %0b read_value %h", got.success,
             got.read_value);
      fail_count++;
    end else begin
      want = pending_replies.pop_front();
      replies_checked++;
      if (got.success !== want.success) begin
        $error("success mismatch: expected %0b, actual %0b", want.success, got.success);
        fail_count++;
      end
      if (got.read_value !== want.read_value) begin
        $error("read_value mismatch: expected %h, actual %h", want.read_value,
               got.read_value);
        fail_count++;
      end
      if (got.found_position !== want.found_position) begin
        $error("found_position mismatch: expected %0d, actual %0d", want.found_position,
               got.found_position);
        fail_count++;
      end
      if (got.entry_count !== want.entry_count) begin
        $error("entry_count mismatch: expected %0d, actual %0d", want.entry_count,
               got.entry_count);
        fail_count++;
      end
    end
  endtask

  // Check each result, then pick out_tready for the next cycle, with random stall bursts.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) check_reply();
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(1, 18) - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------- stimulus side

  // Leaves in_tvalid high after the handshake; the next call or wait_idle settles it.
  task automatic send_op(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
      logic [POS2_W-1:0] pos2, logic [VAL_W-1:0] val);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {{PAD_W{1'b0}}, val, pos2, pos};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_replies.push_back(compute_list_reply(op, pos, pos2, val));
    ops_sent++;
    if (live_count > peak_count) peak_count = live_count;
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(ile_cfg_e_t idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_GROW:   grow_en   = data[0];
      CFG_SHRINK: shrink_en = data[0];
      CFG_STEP:   step_amt  = int'(data);
      CFG_INIT:   init_size = int'(data);
      default: ;
    endcase
  endtask

  // Program all four registers on an idle block, then clear so the initial size loads.
  task automatic apply_setting(bit grow, bit shrink, logic [CFG_DATA_W-1:0] step,
      logic [CFG_DATA_W-1:0] init);
    wait_idle();
    write_reg(CFG_GROW, CFG_DATA_W'(grow));
    write_reg(CFG_SHRINK, CFG_DATA_W'(shrink));
    write_reg(CFG_STEP, step);
    write_reg(CFG_INIT, init);
    cfg_valid <= 1'b0;
    settings_used++;
    send_op(OP_CLEAR, '0, '0, '0);
  endtask

  function automatic logic [OP_W-1:0] pick_op(op_mix_t mix);
    int wt[12];
    int total;
    int r;
    // insert append remove pop dequeue read write find remval exchange clear unknown
    case (mix)
      MIX_FILL:  wt = '{28, 20, 6, 3, 3, 8, 6, 8, 5, 6, 1, 3};
      MIX_DRAIN: wt = '{8, 5, 20, 10, 10, 8, 5, 8, 12, 6, 1, 3};
      default:   wt = '{14, 10, 10, 5, 5, 10, 8, 10, 8, 10, 2, 3};
    endcase
    total = 0;
    foreach (wt[i]) total += wt[i];
    r = $urandom_range(0, total - 1);
    foreach (wt[i]) begin
      if (r < wt[i]) begin
        if (i < 11) return op_order[i];
        return OP_W'($urandom_range(int'(OP_CLEAR) + 1, int'(OP_UNKNOWN_HI)));
      end
      r -= wt[i];
    end
    return OP_CLEAR;
  endfunction

  // Indexes mostly land in or just past the live range; values often repeat or
  // match a live entry so that searches hit.
  task automatic run_random_ops(int n, op_mix_t mix);
    logic [OP_W-1:0]   op;
    logic [POS_W-1:0]  pos;
    logic [POS2_W-1:0] pos2;
    logic [VAL_W-1:0]  val;
    int near;
    int r;
    repeat (n) begin
      op   = pick_op(mix);
      near = (live_count > 63) ? 63 : live_count;
      if ($urandom_range(0, 9) < 8) pos = POS_W'($urandom_range(0, live_count));
      else pos = POS_W'($urandom_range(0, 127));
      if ($urandom_range(0, 9) < 8) pos2 = POS2_W'($urandom_range(0, near));
      else pos2 = POS2_W'($urandom_range(0, 63));
      r = $urandom_range(0, 9);
      if (r < 4 || live_count == 0) val = $urandom;
      else if (r < 7) val = value_pool[$urandom_range(0, 7)];
      else val = list_mem[$urandom_range(0, live_count - 1)];
      send_op(op, pos, pos2, val);
    end
  endtask

  // ---------------------------------------------------------------- tests

  // Register defaults from reset: growth on by one, no shrinking, size zero.
  task automatic test_directed_ops();
    send_op(OP_POP, 7'd0, 6'd0, 32'h0);                 // empty list
    send_op(OP_DEQUEUE, 7'd0, 6'd0, 32'h0);
    send_op(OP_READ, 7'd0, 6'd0, 32'h0);
    send_op(OP_INSERT, 7'd1, 6'd0, 32'h1111_1111);       // past the count: rejected
    send_op(OP_INSERT, 7'd0, 6'd0, 32'h0000_0000);
    send_op(OP_APPEND, 7'd0, 6'd0, 32'hFFFF_FFFF);
    send_op(OP_APPEND, 7'd0, 6'd0, 32'h1234_5678);
    send_op(OP_INSERT, 7'd1, 6'd0, 32'hA5A5_A5A5);       // middle, shifts up
    send_op(OP_INSERT, 7'd4, 6'd0, 32'h5A5A_5A5A);       // at the count
    send_op(OP_READ, 7'd127, 6'd0, 32'h0);
    send_op(OP_READ, 7'd3, 6'd0, 32'h0);
    send_op(OP_WRITE, 7'd0, 6'd0, 32'h1234_5678);        // duplicate value
    send_op(OP_FIND, 7'd0, 6'd0, 32'h1234_5678);         // first of two
    send_op(OP_FIND, 7'd0, 6'd0, 32'hDEAD_BEEF);         // miss
    send_op(OP_REMVAL, 7'd0, 6'd0, 32'h1234_5678);
    send_op(OP_REMVAL, 7'd0, 6'd0, 32'hDEAD_BEEF);
    send_op(OP_EXCHANGE, 7'd0, 6'd3, 32'h0);
    send_op(OP_EXCHANGE, 7'd0, 6'd63, 32'h0);            // second index out of range
    send_op(OP_WRITE, 7'd4, 6'd0, 32'hCAFE_F00D);        // at the count: fails
    send_op(OP_REMOVE, 7'd1, 6'd0, 32'h0);
    send_op(OP_REMOVE, 7'd3, 6'd0, 32'h0);
    send_op(OP_POP, 7'd0, 6'd0, 32'h0);
    send_op(OP_DEQUEUE, 7'd0, 6'd0, 32'h0);
    send_op(OP_UNKNOWN_HI, 7'd64, 6'd42, 32'h8000_0001);
    send_op(OP_CLEAR, 7'd0, 6'd0, 32'h0);
  endtask

  task automatic test_default_sizing();
    apply_setting(1'b1, 1'b0, 7'd1, 7'd0);
    run_random_ops(220, MIX_BALANCED);
  endtask

  // Second half hits the case of a step larger than the current size.
  task automatic test_shrink_by_step();
    apply_setting(1'b1, 1'b1, 7'd3, 7'd8);
    run_random_ops(220, MIX_BALANCED);
    apply_setting(1'b1, 1'b1, 7'd21, 7'd5);
    run_random_ops(110, MIX_FILL);
    run_random_ops(110, MIX_DRAIN);
  endtask

  // Initial size above capacity saturates; the list then fills to capacity.
  task automatic test_full_capacity();
    apply_setting(1'b0, 1'b0, 7'd1, 7'd100);
    run_random_ops(220, MIX_FILL);
  endtask

  // A step as large as capacity, a zero step and growth disabled; a zero step refuses the insert once the size is full.
  task automatic test_growth_limits();
    apply_setting(1'b1, 1'b1, 7'd64, 7'd0);
    run_random_ops(220, MIX_BALANCED);
    apply_setting(1'b1, 1'b1, 7'd0, 7'd12);
    run_random_ops(220, MIX_BALANCED);
    apply_setting(1'b0, 1'b1, 7'd2, 7'd64);
    run_random_ops(100, MIX_FILL);
    run_random_ops(100, MIX_DRAIN);
  endtask

  task automatic test_back_to_back();
    apply_setting(1'b1, 1'b1, 7'd1, 7'd0);
    wait_idle();
    idle_en = 1'b0;
    run_random_ops(200, MIX_BALANCED);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_ops();
    test_default_sizing();
    test_shrink_by_step();
    test_full_capacity();
    test_growth_limits();
    test_back_to_back();
    wait_idle();
    repeat (20) @(posedge clk);
    $display("Ran %0d operations under %0d register settings; %0d results checked.",
             ops_sent, settings_used, replies_checked);
    $display("Deepest list seen: %0d of %0d entries.", peak_count, CAP);
    if (fail_count == 0) $display("PASS indexed_list_engine");
    else $display("FAIL indexed_list_engine");
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #5_000_000;
    $display("FAIL indexed_list_engine");
    $finish;
  end

endmodule
